// File: hdl/bep_pkg.sv
// Package: shared constants, types and the rate lookup for the beacon element parser.
`default_nettype none
package bep_pkg;

    localparam int HEADER_BYTES = 12;
    localparam int MAX_SSID_DEF = 32;
    localparam int BANK_W       = 2;

    localparam logic [3:0] CAPS_LO_POS = 4'd10;
    localparam logic [3:0] CAPS_HI_POS = 4'd11;

    localparam logic [7:0] ID_SSID      = 8'd0;
    localparam logic [7:0] ID_RATES     = 8'd1;
    localparam logic [7:0] ID_DS        = 8'd3;
    localparam logic [7:0] ID_RSN       = 8'd48;
    localparam logic [7:0] ID_EXT_RATES = 8'd50;
    localparam logic [7:0] ID_VENDOR    = 8'd221;

    localparam logic [23:0] OUI_IEEE    = 24'h000FAC;
    localparam logic [23:0] OUI_WPA     = 24'h0050F2;
    localparam logic [31:0] WPA_TAG     = 32'h0050F201;
    localparam logic [15:0] RSN_VERSION = 16'h0100;
    localparam logic [7:0]  CIPHER_TKIP = 8'd2;
    localparam logic [7:0]  CIPHER_AES  = 8'd4;

    localparam logic [15:0] UNKNOWN_RATE = 16'h8000;
    localparam logic [7:0]  AUTH_OPEN    = 8'h01;
    localparam logic [7:0]  AUTH_WEP     = 8'h0E;
    localparam logic [7:0]  AUTH_WPA_TKIP  = 8'h10;
    localparam logic [7:0]  AUTH_WPA_AES   = 8'h20;
    localparam logic [7:0]  AUTH_WPA2_TKIP = 8'h40;
    localparam logic [7:0]  AUTH_WPA2_AES  = 8'h80;
    localparam int          PRIVACY_BIT  = 4;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_SSID,
        EM_SUM
    } emit_state_t;

    typedef struct packed {
        logic        header_ok;
        logic [15:0] capabilities;
        logic [5:0]  ssid_length;
        logic [7:0]  channel_number;
        logic [15:0] all_rates;
        logic [15:0] basic_rates;
        logic [7:0]  auth_bits;
    } summary_t;

    localparam logic [7:0] RATE_TABLE [12] = '{
        8'd2, 8'd4, 8'd11, 8'd12, 8'd18, 8'd22,
        8'd24, 8'd36, 8'd48, 8'd72, 8'd96, 8'd108
    };

    function automatic logic [15:0] rate_bit(input logic [6:0] rate);
        logic [15:0] bits;
        bits = 16'd0;
        for (int k = 0; k < 12; k++) begin
            if (RATE_TABLE[k] == {1'b0, rate}) begin
                bits[k] = 1'b1;
            end
        end
        if (bits == 16'd0) begin
            bits = UNKNOWN_RATE;
        end
        return bits;
    endfunction

endpackage
`default_nettype wire

// File: hdl/bep_ssid_mem.sv
// SSID byte store: three banks, one write port, one registered read port.
`default_nettype none
module bep_ssid_mem #(
    parameter int AW = 5
) (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [bep_pkg::BANK_W+AW-1:0] wr_addr,
    input  wire logic [7:0]                    wr_data,
    input  wire logic [bep_pkg::BANK_W+AW-1:0] rd_addr,
    output logic      [7:0]                    rd_data
);
    import bep_pkg::*;

    localparam int DEPTH = 3 << AW;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: hdl/bep_parser.sv
// Byte parser: fixed header, element decode, SSID staging and per-frame summary.
`default_nettype none
module bep_parser #(
    parameter int MAX_SSID = bep_pkg::MAX_SSID_DEF,
    parameter int AW       = 5,
    parameter int CNT_W    = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    input  wire logic                          s_frame_end,
    input  wire logic                          emit_idle,
    output logic                               wr_en,
    output logic      [bep_pkg::BANK_W+AW-1:0] wr_addr,
    output logic      [7:0]                    wr_data,
    output logic                               done,
    output logic      [CNT_W-1:0]              done_count,
    output logic      [bep_pkg::BANK_W-1:0]    done_bank,
    output bep_pkg::summary_t                  done_sum
);
    import bep_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [3:0]          hc_reg, hc_next;
    logic [15:0]         caps_reg, caps_next;
    logic [7:0]          id_reg, id_next;
    logic [7:0]          len_reg, len_next;
    logic [7:0]          off_reg, off_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]          chan_reg, chan_next;
    logic [15:0]         pall_reg, pall_next;
    logic [15:0]         pbas_reg, pbas_next;
    logic [15:0]         aall_reg, aall_next;
    logic [15:0]         abas_reg, abas_next;
    logic [15:0]         scnt_reg, scnt_next;
    logic [31:0]         sb_reg, sb_next;
    logic [7:0]          pauth_reg, pauth_next;
    logic [7:0]          auth_reg, auth_next;
    logic                sec_reg, sec_next;
    logic                ver_reg, ver_next;
    logic                wpa_reg, wpa_next;
    logic [BANK_W-1:0]   ebank_reg, ebank_next;
    logic [BANK_W-1:0]   cbank_reg, cbank_next;
    logic [BANK_W-1:0]   sbank_reg, sbank_next;

    logic accept;

    assign s_ready = emit_idle || !s_frame_end;
    assign accept  = s_valid && s_ready;

    always_comb begin
        logic [31:0] sb_n;
        logic [15:0] rbit;
        logic        suite_en;
        logic        wpa2;
        logic [7:0]  soff;
        logic [5:0]  sidx;
        logic [7:0]  flen;
        logic        fin_en;
        logic [18:0] need;
        logic [BANK_W-1:0] tmp_bank;

        phase_next = phase_reg;
        hc_next    = hc_reg;
        caps_next  = caps_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        off_next   = off_reg;
        cnt_next   = cnt_reg;
        chan_next  = chan_reg;
        pall_next  = pall_reg;
        pbas_next  = pbas_reg;
        aall_next  = aall_reg;
        abas_next  = abas_reg;
        scnt_next  = scnt_reg;
        sb_next    = sb_reg;
        pauth_next = pauth_reg;
        auth_next  = auth_reg;
        sec_next   = sec_reg;
        ver_next   = ver_reg;
        wpa_next   = wpa_reg;
        ebank_next = ebank_reg;
        cbank_next = cbank_reg;
        sbank_next = sbank_reg;

        wr_en      = 1'b0;
        wr_addr    = {sbank_reg, off_reg[AW-1:0]};
        wr_data    = s_data_byte;
        done       = 1'b0;
        done_count = '0;
        done_bank  = '0;
        done_sum   = '0;

        sb_n     = {sb_reg[23:0], s_data_byte};
        rbit     = rate_bit(s_data_byte[6:0]);
        wpa2     = (id_reg == ID_RSN);
        suite_en = 1'b0;
        soff     = off_reg;
        sidx     = 6'd0;
        flen     = len_reg;
        fin_en   = 1'b0;
        need     = 19'd0;
        tmp_bank = '0;

        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hc_reg == CAPS_LO_POS) begin
                        caps_next[7:0] = s_data_byte;
                    end else if (hc_reg == CAPS_HI_POS) begin
                        caps_next[15:8] = s_data_byte;
                    end
                    hc_next = hc_reg + 4'd1;
                    if (32'(hc_next) >= HEADER_BYTES) begin
                        phase_next = PH_ID;
                    end
                end
                PH_ID: begin
                    id_next    = s_data_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    len_next   = s_data_byte;
                    pall_next  = 16'd0;
                    pbas_next  = 16'd0;
                    pauth_next = 8'd0;
                    scnt_next  = 16'd0;
                    sb_next    = 32'd0;
                    ver_next   = 1'b0;
                    wpa_next   = 1'b0;
                    off_next   = 8'd0;
                    if (s_data_byte == 8'd0) begin
                        phase_next = PH_ID;
                        if (id_reg == ID_SSID) begin
                            cnt_next = '0;
                        end else if (id_reg == ID_RSN) begin
                            sec_next = 1'b1;
                        end
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    unique case (id_reg)
                        ID_SSID: begin
                            if (32'(off_reg) < MAX_SSID) begin
                                wr_en = 1'b1;
                            end
                        end
                        ID_RATES, ID_EXT_RATES: begin
                            pall_next = pall_reg | rbit;
                            if (s_data_byte[7]) begin
                                pbas_next = pbas_reg | rbit;
                            end
                        end
                        ID_DS: begin
                            if (off_reg == 8'd0) begin
                                sb_next = {24'd0, s_data_byte};
                            end
                        end
                        ID_RSN: begin
                            suite_en = 1'b1;
                        end
                        ID_VENDOR: begin
                            if (off_reg < 8'd4) begin
                                sb_next = sb_n;
                                if (off_reg == 8'd3) begin
                                    wpa_next = (sb_n == WPA_TAG);
                                    sb_next  = 32'd0;
                                end
                            end else if (wpa_reg) begin
                                suite_en = 1'b1;
                                soff     = off_reg - 8'd4;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (suite_en) begin
                        sb_next = sb_n;
                        if (soff == 8'd1) begin
                            ver_next = (sb_n[15:0] == RSN_VERSION);
                        end else if (soff == 8'd7) begin
                            scnt_next = {sb_n[7:0], sb_n[15:8]};
                        end else if (soff >= 8'd8 && soff[1:0] == 2'd3) begin
                            sidx = 6'((soff - 8'd8) >> 2);
                            if (16'(sidx) < scnt_reg &&
                                sb_n[31:8] == (wpa2 ? OUI_IEEE : OUI_WPA)) begin
                                if (s_data_byte == CIPHER_TKIP) begin
                                    pauth_next = pauth_reg |
                                        (wpa2 ? AUTH_WPA2_TKIP : AUTH_WPA_TKIP);
                                end else if (s_data_byte == CIPHER_AES) begin
                                    pauth_next = pauth_reg |
                                        (wpa2 ? AUTH_WPA2_AES : AUTH_WPA_AES);
                                end
                            end
                        end
                    end

                    off_next = off_reg + 8'd1;
                    if (off_next == len_reg) begin
                        phase_next = PH_ID;
                        unique case (id_reg)
                            ID_SSID: begin
                                if (32'(len_reg) <= MAX_SSID) begin
                                    cnt_next   = CNT_W'(len_reg);
                                    cbank_next = sbank_reg;
                                    sbank_next = cbank_reg;
                                end
                            end
                            ID_RATES, ID_EXT_RATES: begin
                                aall_next = aall_reg | pall_next;
                                abas_next = abas_reg | pbas_next;
                            end
                            ID_DS: begin
                                chan_next = sb_next[7:0];
                            end
                            ID_RSN: begin
                                fin_en = 1'b1;
                            end
                            ID_VENDOR: begin
                                if (len_reg >= 8'd4 && wpa_next) begin
                                    fin_en = 1'b1;
                                    flen   = len_reg - 8'd4;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (fin_en) begin
                            sec_next = 1'b1;
                            need     = (19'(scnt_next) << 2) + 19'd8;
                            if (flen >= 8'd8 && ver_next && need <= 19'(flen)) begin
                                auth_next = auth_reg | pauth_next;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if (s_frame_end) begin
                done      = 1'b1;
                done_bank = cbank_next;
                if (phase_next != PH_HEADER) begin
                    done_count            = cnt_next;
                    done_sum.header_ok    = 1'b1;
                    done_sum.capabilities = caps_next;
                    done_sum.ssid_length  = 6'(cnt_next);
                    done_sum.channel_number = chan_next;
                    done_sum.all_rates    = aall_next;
                    done_sum.basic_rates  = abas_next;
                    if (sec_next) begin
                        done_sum.auth_bits = auth_next;
                    end else if (caps_next[PRIVACY_BIT]) begin
                        done_sum.auth_bits = AUTH_WEP;
                    end else begin
                        done_sum.auth_bits = AUTH_OPEN;
                    end
                end
                tmp_bank   = cbank_next;
                cbank_next = ebank_reg;
                ebank_next = tmp_bank;
                phase_next = PH_HEADER;
                hc_next    = 4'd0;
                caps_next  = 16'd0;
                id_next    = 8'd0;
                len_next   = 8'd0;
                off_next   = 8'd0;
                cnt_next   = '0;
                chan_next  = 8'd0;
                pall_next  = 16'd0;
                pbas_next  = 16'd0;
                aall_next  = 16'd0;
                abas_next  = 16'd0;
                scnt_next  = 16'd0;
                sb_next    = 32'd0;
                pauth_next = 8'd0;
                auth_next  = 8'd0;
                sec_next   = 1'b0;
                ver_next   = 1'b0;
                wpa_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hc_reg    <= 4'd0;
            caps_reg  <= 16'd0;
            id_reg    <= 8'd0;
            len_reg   <= 8'd0;
            off_reg   <= 8'd0;
            cnt_reg   <= '0;
            chan_reg  <= 8'd0;
            pall_reg  <= 16'd0;
            pbas_reg  <= 16'd0;
            aall_reg  <= 16'd0;
            abas_reg  <= 16'd0;
            scnt_reg  <= 16'd0;
            sb_reg    <= 32'd0;
            pauth_reg <= 8'd0;
            auth_reg  <= 8'd0;
            sec_reg   <= 1'b0;
            ver_reg   <= 1'b0;
            wpa_reg   <= 1'b0;
            ebank_reg <= BANK_W'(0);
            cbank_reg <= BANK_W'(1);
            sbank_reg <= BANK_W'(2);
        end else begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            caps_reg  <= caps_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            off_reg   <= off_next;
            cnt_reg   <= cnt_next;
            chan_reg  <= chan_next;
            pall_reg  <= pall_next;
            pbas_reg  <= pbas_next;
            aall_reg  <= aall_next;
            abas_reg  <= abas_next;
            scnt_reg  <= scnt_next;
            sb_reg    <= sb_next;
            pauth_reg <= pauth_next;
            auth_reg  <= auth_next;
            sec_reg   <= sec_next;
            ver_reg   <= ver_next;
            wpa_reg   <= wpa_next;
            ebank_reg <= ebank_next;
            cbank_reg <= cbank_next;
            sbank_reg <= sbank_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/bep_emitter.sv
// Result sequencer: SSID bytes from the frozen bank, then the summary item.
`default_nettype none
module bep_emitter #(
    parameter int AW    = 5,
    parameter int CNT_W = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [CNT_W-1:0]              start_count,
    input  wire logic [bep_pkg::BANK_W-1:0]    start_bank,
    input  wire bep_pkg::summary_t             start_sum,
    output logic                               idle,
    output logic      [bep_pkg::BANK_W+AW-1:0] rd_addr,
    input  wire logic [7:0]                    rd_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [7:0]                    m_ssid_char,
    output logic      [4:0]                    m_ssid_pos,
    output logic                               m_run_last,
    output logic                               m_header_ok,
    output logic      [15:0]                   m_capabilities,
    output logic      [5:0]                    m_ssid_length,
    output logic      [7:0]                    m_channel_number,
    output logic      [15:0]                   m_all_rates,
    output logic      [15:0]                   m_basic_rates,
    output logic      [7:0]                    m_auth_bits
);
    import bep_pkg::*;

    emit_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [BANK_W-1:0]  bank_reg, bank_next;
    summary_t           sum_reg, sum_next;
    summary_t           sum_out;

    assign rd_addr = {bank_reg, idx_reg[AW-1:0]};

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        bank_next  = bank_reg;
        sum_next   = sum_reg;
        idle       = 1'b0;
        m_valid    = 1'b0;
        m_ssid_char = 8'd0;
        m_ssid_pos  = 5'd0;
        m_run_last  = 1'b0;
        sum_out     = '0;
        unique case (state_reg)
            EM_IDLE: begin
                idle = 1'b1;
                if (start) begin
                    idx_next   = '0;
                    count_next = start_count;
                    bank_next  = start_bank;
                    sum_next   = start_sum;
                    state_next = (start_count == '0) ? EM_SUM : EM_READ;
                end
            end
            EM_READ: begin
                state_next = EM_SSID;
            end
            EM_SSID: begin
                m_valid     = 1'b1;
                m_ssid_char = rd_data;
                m_ssid_pos  = 5'(idx_reg);
                if (m_ready) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_next == count_reg) ? EM_SUM : EM_READ;
                end
            end
            EM_SUM: begin
                m_valid    = 1'b1;
                m_run_last = 1'b1;
                sum_out    = sum_reg;
                if (m_ready) begin
                    state_next = EM_IDLE;
                end
            end
            default: begin
                state_next = EM_IDLE;
            end
        endcase
    end

    assign m_header_ok      = sum_out.header_ok;
    assign m_capabilities   = sum_out.capabilities;
    assign m_ssid_length    = sum_out.ssid_length;
    assign m_channel_number = sum_out.channel_number;
    assign m_all_rates      = sum_out.all_rates;
    assign m_basic_rates    = sum_out.basic_rates;
    assign m_auth_bits      = sum_out.auth_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
        count_reg <= count_next;
        bank_reg  <= bank_next;
        sum_reg   <= sum_next;
    end

endmodule
`default_nettype wire

// File: hdl/beacon_element_parser_top.sv
// Top level of the beacon element parser.
//
//  channel | ports                      | direction | carries
//  --------+----------------------------+-----------+------------------------------
//  s_      | s_valid/s_ready + 2 fields | in        | one beacon body byte per item
//  m_      | m_valid/m_ready + 10 fields| out       | SSID byte items, then summary
//
//  One input byte is taken per cycle while s_ready is high; the parser updates its state in a single pass.
//  A frame end starts ssid_length SSID items, each fetched by the registered
//  read of the SSID store, followed by one summary item.
//  The next frame is parsed while results drain; a second frame end is held off
//  until the previous run has been delivered.
//  Synchronous active-low reset clears the parser state and the emitter state and index; no clearing pass.
`default_nettype none
module beacon_element_parser_top #(
    parameter int MAX_SSID = bep_pkg::MAX_SSID_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_frame_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_ssid_char,
    output logic      [4:0]  m_ssid_pos,
    output logic             m_run_last,
    output logic             m_header_ok,
    output logic      [15:0] m_capabilities,
    output logic      [5:0]  m_ssid_length,
    output logic      [7:0]  m_channel_number,
    output logic      [15:0] m_all_rates,
    output logic      [15:0] m_basic_rates,
    output logic      [7:0]  m_auth_bits
);
    import bep_pkg::*;

    localparam int AW    = (MAX_SSID > 1) ? $clog2(MAX_SSID) : 1;
    localparam int CNT_W = $clog2(MAX_SSID + 1);

    logic                 emit_idle;
    logic                 wr_en;
    logic [BANK_W+AW-1:0] wr_addr;
    logic [7:0]           wr_data;
    logic [BANK_W+AW-1:0] rd_addr;
    logic [7:0]           rd_data;
    logic                 done;
    logic [CNT_W-1:0]     done_count;
    logic [BANK_W-1:0]    done_bank;
    summary_t             done_sum;

    bep_parser #(
        .MAX_SSID (MAX_SSID),
        .AW       (AW),
        .CNT_W    (CNT_W)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .emit_idle   (emit_idle),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .done        (done),
        .done_count  (done_count),
        .done_bank   (done_bank),
        .done_sum    (done_sum)
    );

    bep_ssid_mem #(
        .AW (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bep_emitter #(
        .AW    (AW),
        .CNT_W (CNT_W)
    ) u_emitter (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .start            (done),
        .start_count      (done_count),
        .start_bank       (done_bank),
        .start_sum        (done_sum),
        .idle             (emit_idle),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ssid_char      (m_ssid_char),
        .m_ssid_pos       (m_ssid_pos),
        .m_run_last       (m_run_last),
        .m_header_ok      (m_header_ok),
        .m_capabilities   (m_capabilities),
        .m_ssid_length    (m_ssid_length),
        .m_channel_number (m_channel_number),
        .m_all_rates      (m_all_rates),
        .m_basic_rates    (m_basic_rates),
        .m_auth_bits      (m_auth_bits)
    );

endmodule
`default_nettype wire

// File: hdl/bep_checker.sv
// Port checker for the beacon element parser, bound to the top level.
`default_nettype none
module bep_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_ssid_char,
    input wire logic [4:0]  m_ssid_pos,
    input wire logic        m_run_last,
    input wire logic        m_header_ok,
    input wire logic [15:0] m_capabilities,
    input wire logic [5:0]  m_ssid_length,
    input wire logic [7:0]  m_auth_bits
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    a_ssid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_last |-> !m_header_ok && m_capabilities == 16'd0 &&
            m_auth_bits == 8'd0 && m_ssid_length == 6'd0)
        else $error("summary fields set on an SSID item");

    a_sum_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_last |-> m_ssid_char == 8'd0 && m_ssid_pos == 5'd0)
        else $error("SSID fields set on a summary item");

    a_short_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_run_last && !m_header_ok |-> m_capabilities == 16'd0 &&
            m_auth_bits == 8'd0 && m_ssid_length == 6'd0)
        else $error("short frame summary not cleared");

endmodule

bind beacon_element_parser_top bep_checker u_bep_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_ssid_char    (m_ssid_char),
    .m_ssid_pos     (m_ssid_pos),
    .m_run_last     (m_run_last),
    .m_header_ok    (m_header_ok),
    .m_capabilities (m_capabilities),
    .m_ssid_length  (m_ssid_length),
    .m_auth_bits    (m_auth_bits)
);
`default_nettype wire
